// ===== sv/srfd_pkg.sv =====
// Shared types and constants for the sensor reply frame deframer.
`timescale 1ns / 1ps

package srfd_pkg;

    localparam int MAX_LENGTH_DEF = 255;

    localparam int POS_W   = 9;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int SUM_W   = 16;

    localparam logic [BYTE_W-1:0] HDR_BYTE0   = 8'hEF;
    localparam logic [BYTE_W-1:0] HDR_BYTE1   = 8'h01;
    localparam logic [BYTE_W-1:0] FIX_ID      = 8'h07;
    localparam logic [BYTE_W-1:0] FIX_LEN_LOW = 8'h19;
    localparam logic [SUM_W-1:0]  FIX_SUB     = 16'd6;
    localparam logic [LEN_W-1:0]  ADDR_BYTES  = 16'd4;
    localparam logic [LEN_W-1:0]  LEN_MIN     = 16'd2;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_HDR2 = 4'd1,
        PH_ADDR = 4'd2,
        PH_ID   = 4'd3,
        PH_LENH = 4'd4,
        PH_LENL = 4'd5,
        PH_PAY  = 4'd6,
        PH_CKH  = 4'd7,
        PH_CKL  = 4'd8,
        PH_HELD = 4'd9
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] byte_out;
        logic              frame_end;
        logic              checksum_ok;
    } result_t;

endpackage

// ===== sv/sensor_reply_frame_deframer_unit.sv =====
// Top level of the sensor reply frame deframer.
`timescale 1ns / 1ps

// Watches a stream of received serial bytes for reply frames: 0xEF, 0x01,
// four unchecked address bytes, packet id, 16-bit length (high byte first),
// length-2 payload bytes and a 16-bit checksum. Every byte the frame takes
// is echoed with its frame position; the last checksum byte carries
// frame_end and checksum_ok. A good frame parks the deframer, which then
// drops received bytes until a release item (s_operation = 1) arrives.
// Lengths below 2 or above MaxLength drop the frame silently. Each item is
// handled at the input handshake: the parser state and running sum update
// there and the result lands in a single output register, so a new item is
// taken every cycle as long as that register is empty or being drained in
// the same cycle.
module sensor_reply_frame_deframer_unit #(
    parameter int MaxLength = srfd_pkg::MAX_LENGTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [srfd_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [srfd_pkg::POS_W-1:0]    m_position,
    output logic [srfd_pkg::BYTE_W-1:0]   m_byte_out,
    output logic                          m_frame_end,
    output logic                          m_checksum_ok
);

    logic              slot_free;
    logic              item_accept;
    srfd_pkg::result_t result;

    // Take an item whenever the output slot can absorb a possible result.
    assign s_ready     = slot_free;
    assign item_accept = s_valid && s_ready;

    // Advance the frame state on every accepted item.
    srfd_parser #(
        .MaxLength (MaxLength)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .item_op     (s_operation),
        .item_byte   (s_rx_byte),
        .result      (result)
    );

    // Hold the echoed byte until the consumer takes it.
    srfd_out_reg u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .result        (result),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_position    (m_position),
        .m_byte_out    (m_byte_out),
        .m_frame_end   (m_frame_end),
        .m_checksum_ok (m_checksum_ok),
        .slot_free     (slot_free)
    );

    // A pass flag only ever rides on the last checksum byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_checksum_ok |-> m_frame_end)
        else $error("checksum_ok without frame_end");

    // Frame start is always the header byte at position zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_position == '0 |-> m_byte_out == srfd_pkg::HDR_BYTE0 && !m_frame_end)
        else $error("position zero carries a non-header byte");

    // An empty output slot must never stall the input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    // Accepted release produces no result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == srfd_pkg::OP_RELEASE |=> !m_valid)
        else $error("release item produced a result");

endmodule

// ===== sv/srfd_parser.sv =====
// Frame parser: phase machine, running checksum and result formation.
`timescale 1ns / 1ps

module srfd_parser #(
    parameter int MaxLength = srfd_pkg::MAX_LENGTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_accept,
    input  logic                          item_op,
    input  logic [srfd_pkg::BYTE_W-1:0]   item_byte,
    output srfd_pkg::result_t             result
);

    localparam logic [srfd_pkg::LEN_W-1:0] LenMax = srfd_pkg::LEN_W'(MaxLength);

    srfd_pkg::phase_t                phase_reg, phase_next;
    logic [srfd_pkg::LEN_W-1:0]      left_reg, left_next;
    logic [srfd_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [srfd_pkg::BYTE_W-1:0]     id_reg, id_next;
    logic [srfd_pkg::BYTE_W-1:0]     lenh_reg, lenh_next;
    logic [srfd_pkg::BYTE_W-1:0]     lenl_reg, lenl_next;
    logic [srfd_pkg::BYTE_W-1:0]     ckh_reg, ckh_next;
    logic [srfd_pkg::POS_W-1:0]      pos_reg, pos_next;

    logic [srfd_pkg::LEN_W-1:0]      len;
    logic [srfd_pkg::SUM_W-1:0]      sum_byte;
    logic [srfd_pkg::SUM_W-1:0]      sum_final;
    logic [srfd_pkg::POS_W-1:0]      pos_inc;

    assign len      = {lenh_reg, item_byte};
    assign sum_byte = sum_reg + srfd_pkg::SUM_W'(item_byte);
    assign pos_inc  = pos_reg + srfd_pkg::POS_W'(1);
    assign sum_final = (id_reg == srfd_pkg::FIX_ID && lenl_reg == srfd_pkg::FIX_LEN_LOW)
                     ? sum_reg - srfd_pkg::FIX_SUB : sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= srfd_pkg::PH_IDLE;
            left_reg  <= '0;
            sum_reg   <= '0;
            id_reg    <= '0;
            lenh_reg  <= '0;
            lenl_reg  <= '0;
            ckh_reg   <= '0;
            pos_reg   <= '0;
        end else if (item_accept) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            id_reg    <= id_next;
            lenh_reg  <= lenh_next;
            lenl_reg  <= lenl_next;
            ckh_reg   <= ckh_next;
            pos_reg   <= pos_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        id_next    = id_reg;
        lenh_next  = lenh_reg;
        lenl_next  = lenl_reg;
        ckh_next   = ckh_reg;
        pos_next   = pos_reg;

        result.valid       = 1'b0;
        result.position    = pos_inc;
        result.byte_out    = item_byte;
        result.frame_end   = 1'b0;
        result.checksum_ok = 1'b0;

        if (item_op == srfd_pkg::OP_RELEASE) begin
            if (phase_reg == srfd_pkg::PH_HELD) begin
                phase_next = srfd_pkg::PH_IDLE;
            end
        end else begin
            unique case (phase_reg)
                srfd_pkg::PH_HDR2: begin
                    if (item_byte != srfd_pkg::HDR_BYTE1) begin
                        phase_next = srfd_pkg::PH_IDLE;
                    end else begin
                        phase_next   = srfd_pkg::PH_ADDR;
                        left_next    = srfd_pkg::ADDR_BYTES;
                        pos_next     = pos_inc;
                        result.valid = 1'b1;
                    end
                end
                srfd_pkg::PH_ADDR: begin
                    left_next = left_reg - srfd_pkg::LEN_W'(1);
                    if (left_next == '0) begin
                        phase_next = srfd_pkg::PH_ID;
                    end
                    pos_next     = pos_inc;
                    result.valid = 1'b1;
                end
                srfd_pkg::PH_ID: begin
                    id_next      = item_byte;
                    sum_next     = srfd_pkg::SUM_W'(item_byte);
                    phase_next   = srfd_pkg::PH_LENH;
                    pos_next     = pos_inc;
                    result.valid = 1'b1;
                end
                srfd_pkg::PH_LENH: begin
                    lenh_next    = item_byte;
                    sum_next     = sum_byte;
                    phase_next   = srfd_pkg::PH_LENL;
                    pos_next     = pos_inc;
                    result.valid = 1'b1;
                end
                srfd_pkg::PH_LENL: begin
                    if (len < srfd_pkg::LEN_MIN || len > LenMax) begin
                        phase_next = srfd_pkg::PH_IDLE;
                    end else begin
                        lenl_next    = item_byte;
                        sum_next     = sum_byte;
                        left_next    = len - srfd_pkg::LEN_MIN;
                        phase_next   = (len != srfd_pkg::LEN_MIN) ? srfd_pkg::PH_PAY
                                                                  : srfd_pkg::PH_CKH;
                        pos_next     = pos_inc;
                        result.valid = 1'b1;
                    end
                end
                srfd_pkg::PH_PAY: begin
                    sum_next  = sum_byte;
                    left_next = left_reg - srfd_pkg::LEN_W'(1);
                    if (left_next == '0) begin
                        phase_next = srfd_pkg::PH_CKH;
                    end
                    pos_next     = pos_inc;
                    result.valid = 1'b1;
                end
                srfd_pkg::PH_CKH: begin
                    ckh_next     = item_byte;
                    phase_next   = srfd_pkg::PH_CKL;
                    pos_next     = pos_inc;
                    result.valid = 1'b1;
                end
                srfd_pkg::PH_CKL: begin
                    result.checksum_ok = (sum_final == {ckh_reg, item_byte});
                    result.frame_end   = 1'b1;
                    result.valid       = 1'b1;
                    phase_next = result.checksum_ok ? srfd_pkg::PH_HELD : srfd_pkg::PH_IDLE;
                    pos_next   = pos_inc;
                end
                srfd_pkg::PH_HELD: begin
                    phase_next = srfd_pkg::PH_HELD;
                end
                default: begin
                    if (item_byte != srfd_pkg::HDR_BYTE0) begin
                        phase_next = srfd_pkg::PH_IDLE;
                    end else begin
                        phase_next      = srfd_pkg::PH_HDR2;
                        pos_next        = '0;
                        sum_next        = '0;
                        left_next       = '0;
                        result.position = '0;
                        result.valid    = 1'b1;
                    end
                end
            endcase
        end

        if (!item_accept) begin
            result.valid = 1'b0;
        end
    end

endmodule

// ===== sv/srfd_out_reg.sv =====
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps

module srfd_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  srfd_pkg::result_t             result,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [srfd_pkg::POS_W-1:0]    m_position,
    output logic [srfd_pkg::BYTE_W-1:0]   m_byte_out,
    output logic                          m_frame_end,
    output logic                          m_checksum_ok,
    output logic                          slot_free
);

    logic              valid_reg;
    srfd_pkg::result_t data_reg;

    assign slot_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (slot_free) begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && result.valid) begin
            data_reg <= result;
        end
    end

    assign m_valid       = valid_reg;
    assign m_position    = data_reg.position;
    assign m_byte_out    = data_reg.byte_out;
    assign m_frame_end   = data_reg.frame_end;
    assign m_checksum_ok = data_reg.checksum_ok;

endmodule
